FILE: hdl/c16rae_pkg.sv
// Shared types and constants for the 16-bit register ALU execute stage.
// Used by every module in hdl except c16rae_ram; depends on nothing.
package c16rae_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned IdxW = 4;
  localparam int unsigned NumRegs = 16;
  localparam logic [IdxW-1:0] AuxReg = 4'hF;

  typedef logic [WordW-1:0] word_t;
  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [3:0] {
    CMD_COPY  = 4'd0,
    CMD_ADD   = 4'd1,
    CMD_SUB   = 4'd2,
    CMD_AND   = 4'd3,
    CMD_OR    = 4'd4,
    CMD_XOR   = 4'd5,
    CMD_SHIFT = 4'd6,
    CMD_MUL   = 4'd7,
    CMD_STORE = 4'd8,
    CMD_CONST = 4'd9,
    CMD_UGT   = 4'd10,
    CMD_SGT   = 4'd11,
    CMD_ULT   = 4'd12,
    CMD_SLT   = 4'd13,
    CMD_EQ    = 4'd14,
    CMD_MAJ   = 4'd15
  } cmd_t;

  typedef enum logic [1:0] {
    SH_ASR = 2'd0,
    SH_LSR = 2'd1,
    SH_ROL = 2'd2,
    SH_LSL = 2'd3
  } shmode_t;

  typedef struct packed {
    logic  ram_we;
    idx_t  ram_addr;
    word_t ram_data;
    logic  r15_we;
    word_t r15_data;
  } rf_wr_t;

  typedef struct packed {
    logic  write_valid;
    idx_t  write_index;
    word_t write_value;
    logic  aux_valid;
    word_t aux_value;
  } result_t;

endpackage

FILE: hdl/c16rae_ram.sv
// Generic simple dual-read RAM: one write port, two read ports, registered reads.
// Read returns the old contents on a same-cycle write. No dependencies.
module c16rae_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: hdl/c16rae_regfile.sv
// Register file: RAM for registers 0..14 with per-entry valid bits, register 15
// in flops, and bypass of the write in flight. Depends on c16rae_pkg, c16rae_ram.
module c16rae_regfile (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  c16rae_pkg::idx_t   rd_a,
  input  c16rae_pkg::idx_t   rd_b,
  input  c16rae_pkg::rf_wr_t wr,
  output c16rae_pkg::word_t  a_val,
  output c16rae_pkg::word_t  b_val
);
  import c16rae_pkg::*;

  logic [NumRegs-1:0] valid;
  word_t r15;
  word_t q_a;
  word_t q_b;
  word_t fwd_data;
  logic a_is15;
  logic b_is15;
  logic a_fwd;
  logic b_fwd;
  logic a_zero;
  logic b_zero;

  c16rae_ram #(
    .WIDTH(WordW),
    .DEPTH(NumRegs)
  ) u_ram (
    .clk    (clk),
    .we     (wr.ram_we),
    .waddr  (wr.ram_addr),
    .wdata  (wr.ram_data),
    .re     (rd_en),
    .raddr_a(rd_a),
    .raddr_b(rd_b),
    .rdata_a(q_a),
    .rdata_b(q_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      r15   <= '0;
    end else begin
      if (wr.ram_we) begin
        valid[wr.ram_addr] <= 1'b1;
      end
      if (wr.r15_we) begin
        r15 <= wr.r15_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_is15   <= (rd_a == AuxReg);
      b_is15   <= (rd_b == AuxReg);
      a_fwd    <= wr.ram_we && (wr.ram_addr == rd_a);
      b_fwd    <= wr.ram_we && (wr.ram_addr == rd_b);
      a_zero   <= !valid[rd_a];
      b_zero   <= !valid[rd_b];
      fwd_data <= wr.ram_data;
    end
  end

  always_comb begin
    priority if (a_is15) begin
      a_val = r15;
    end else if (a_fwd) begin
      a_val = fwd_data;
    end else if (a_zero) begin
      a_val = '0;
    end else begin
      a_val = q_a;
    end
    priority if (b_is15) begin
      b_val = r15;
    end else if (b_fwd) begin
      b_val = fwd_data;
    end else if (b_zero) begin
      b_val = '0;
    end else begin
      b_val = q_b;
    end
  end

endmodule

FILE: hdl/c16rae_alu.sv
// Combinational execute logic: computes the result fields and register writes
// for one decoded instruction. Depends on c16rae_pkg.
module c16rae_alu (
  input  c16rae_pkg::cmd_t    cmd,
  input  c16rae_pkg::idx_t    dest,
  input  c16rae_pkg::idx_t    src_a,
  input  c16rae_pkg::idx_t    src_b,
  input  c16rae_pkg::word_t   a,
  input  c16rae_pkg::word_t   b,
  output c16rae_pkg::result_t res,
  output c16rae_pkg::rf_wr_t  wr
);
  import c16rae_pkg::*;

  logic [2*WordW-1:0] prod;
  logic [2*WordW-1:0] rot;
  logic [2:0] sh_n;
  shmode_t sh_mode;
  word_t sh;
  word_t val;
  word_t aux;
  logic is_maj;
  logic wvalid;
  logic dest15;

  assign prod    = {16'h0000, a} * {16'h0000, b};
  assign sh_n    = b[2:0];
  assign sh_mode = shmode_t'(b[4:3]);
  assign rot     = {a, a} << sh_n;
  assign is_maj  = (cmd == CMD_MAJ);
  assign wvalid  = (cmd != CMD_STORE);
  assign dest15  = (dest == AuxReg);
  assign aux     = (src_b == dest) ? a : b;

  always_comb begin
    unique case (sh_mode)
      SH_ASR: sh = word_t'($signed(a) >>> sh_n);
      SH_LSR: sh = a >> sh_n;
      SH_ROL: sh = rot[2*WordW-1:WordW];
      SH_LSL: sh = a << sh_n;
      default: sh = a;
    endcase
  end

  always_comb begin
    unique case (cmd)
      CMD_COPY:  val = b;
      CMD_ADD:   val = a + b;
      CMD_SUB:   val = a - b;
      CMD_AND:   val = a & b;
      CMD_OR:    val = a | b;
      CMD_XOR:   val = a ^ b;
      CMD_SHIFT: val = sh;
      CMD_MUL:   val = prod[WordW-1:0];
      CMD_STORE: val = '0;
      CMD_CONST: val = {8'h00, src_a, src_b};
      CMD_UGT:   val = {15'b0, (a > b)};
      CMD_SGT:   val = {15'b0, ($signed(a) > $signed(b))};
      CMD_ULT:   val = {15'b0, (a < b)};
      CMD_SLT:   val = {15'b0, ($signed(a) < $signed(b))};
      CMD_EQ:    val = {15'b0, (a == b)};
      CMD_MAJ:   val = a;
      default:   val = '0;
    endcase
  end

  always_comb begin
    res.write_valid = wvalid;
    res.write_index = wvalid ? dest : '0;
    if (!wvalid) begin
      res.write_value = '0;
    end else if (is_maj && dest15) begin
      res.write_value = aux;
    end else begin
      res.write_value = val;
    end
    res.aux_valid = is_maj;
    res.aux_value = is_maj ? aux : '0;

    wr.ram_we   = wvalid && !dest15;
    wr.ram_addr = dest;
    wr.ram_data = val;
    wr.r15_we   = is_maj || (wvalid && dest15);
    wr.r15_data = is_maj ? aux : val;
  end

endmodule

FILE: hdl/cpu16_register_alu_execute.sv
// Execute stage of a 16-bit register machine with a sixteen-entry register file.
// Depends on c16rae_pkg, c16rae_regfile and c16rae_alu.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one decoded instruction per
//   request: cmd, dest_reg, src_a, src_b. Output channel (out_valid/out_ready)
//   carries one result per instruction: write_valid, write_index, write_value,
//   aux_valid, aux_value, where the values are what the registers end with.
//   The execute stage register takes each accepted request; the result is
//   written into the output register when that stage advances.
//   Throughput: one instruction per cycle unless the output stalls. Operands come
//   from a registered-read RAM at the accept edge; the write of the instruction
//   ahead is bypassed, so dependent instructions issue back to back, no bubble.
//   Reset: all registers read as zero (RAM entries carry valid bits, register
//   15 lives in flops), pipeline and output are emptied. No clearing pass.
//   Stall: when out_ready is low and the output register is full, the execute
//   stage holds its instruction without writing the register file, and
//   in_ready drops until the output register is taken.
module cpu16_register_alu_execute (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         cmd,
  input  logic [3:0]         dest_reg,
  input  logic [3:0]         src_a,
  input  logic [3:0]         src_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               write_valid,
  output logic [3:0]         write_index,
  output logic signed [15:0] write_value,
  output logic               aux_valid,
  output logic signed [15:0] aux_value
);
  import c16rae_pkg::*;

  logic s1_valid;
  cmd_t s1_cmd;
  idx_t s1_dest;
  idx_t s1_a;
  idx_t s1_b;
  logic s1_adv;
  logic in_acc;
  word_t a_val;
  word_t b_val;
  result_t res;
  rf_wr_t wr;
  rf_wr_t wr_g;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    wr_g        = wr;
    wr_g.ram_we = wr.ram_we && s1_adv;
    wr_g.r15_we = wr.r15_we && s1_adv;
  end

  c16rae_regfile u_regfile (
    .clk  (clk),
    .rst  (rst),
    .rd_en(in_acc),
    .rd_a (src_a),
    .rd_b (src_b),
    .wr   (wr_g),
    .a_val(a_val),
    .b_val(b_val)
  );

  c16rae_alu u_alu (
    .cmd  (s1_cmd),
    .dest (s1_dest),
    .src_a(s1_a),
    .src_b(s1_b),
    .a    (a_val),
    .b    (b_val),
    .res  (res),
    .wr   (wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd  <= cmd_t'(cmd);
      s1_dest <= dest_reg;
      s1_a    <= src_a;
      s1_b    <= src_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      write_valid <= res.write_valid;
      write_index <= res.write_index;
      write_value <= res.write_value;
      aux_valid   <= res.aux_valid;
      aux_value   <= res.aux_value;
    end
  end

endmodule

FILE: sim/cpu16_execute_checker.sv
// Checker for the 16-bit register ALU execute stage: tracks the register file,
// predicts each result from accepted requests and compares it with the output.
// Depends on c16rae_pkg.
`timescale 1ns / 100ps

module cpu16_execute_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  cmd,
  input  logic [3:0]  dest_reg,
  input  logic [3:0]  src_a,
  input  logic [3:0]  src_b,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        write_valid,
  input  logic [3:0]  write_index,
  input  logic [15:0] write_value,
  input  logic        aux_valid,
  input  logic [15:0] aux_value,
  output int          fail_count,
  output int          checked,
  output int          pending
);
  import c16rae_pkg::*;

  word_t   regs [NumRegs];
  result_t expected_writes [$];
  int      errors;
  int      results_seen;

  function automatic word_t shift_word(word_t v, word_t ctl);
    logic [2:0] n;
    shmode_t    m;
    n = ctl[2:0];
    m = shmode_t'(ctl[4:3]);
    if (n == 3'd0) return v;
    case (m)
      SH_ASR: return word_t'($signed(v) >>> n);
      SH_LSR: return v >> n;
      SH_ROL: return (v << n) | (v >> (WordW - n));
      default: return v << n;
    endcase
  endfunction

  function automatic result_t execute_instr(cmd_t op, idx_t d, idx_t ia, idx_t ib);
    word_t   a;
    word_t   b;
    word_t   r;
    result_t res;
    a = regs[ia];
    b = regs[ib];
    r = '0;
    res = '0;
    case (op)
      CMD_COPY:  r = b;
      CMD_ADD:   r = a + b;
      CMD_SUB:   r = a - b;
      CMD_AND:   r = a & b;
      CMD_OR:    r = a | b;
      CMD_XOR:   r = a ^ b;
      CMD_SHIFT: r = shift_word(a, b);
      CMD_MUL:   r = a * b;
      CMD_STORE: r = '0;
      CMD_CONST: r = {8'h00, ia, ib};
      CMD_UGT:   r = word_t'(a > b);
      CMD_SGT:   r = word_t'($signed(a) > $signed(b));
      CMD_ULT:   r = word_t'(a < b);
      CMD_SLT:   r = word_t'($signed(a) < $signed(b));
      CMD_EQ:    r = word_t'(a == b);
      default:   r = a;
    endcase
    if (op != CMD_STORE) begin
      regs[d] = r;
      res.write_valid = 1'b1;
      res.write_index = d;
    end
    // MAJ: second source is read after the destination write lands
    if (op == CMD_MAJ) begin
      res.aux_valid = 1'b1;
      res.aux_value = regs[ib];
      regs[AuxReg] = regs[ib];
    end
    if (op != CMD_STORE) res.write_value = regs[d];
    return res;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    if (errors < 20)
      $display("[%0t] %s mismatch: got %h expected %h", $time, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] = '0;
      expected_writes.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_writes.size() == 0) begin
          report_mismatch("unrequested result", write_value, 0);
        end else begin
          want = expected_writes.pop_front();
          if (write_valid !== want.write_valid)
            report_mismatch("write_valid", write_valid, want.write_valid);
          if (write_index !== want.write_index)
            report_mismatch("write_index", write_index, want.write_index);
          if (write_value !== want.write_value)
            report_mismatch("write_value", write_value, want.write_value);
          if (aux_valid !== want.aux_valid)
            report_mismatch("aux_valid", aux_valid, want.aux_valid);
          if (aux_value !== want.aux_value)
            report_mismatch("aux_value", aux_value, want.aux_value);
        end
      end
      if (in_valid && in_ready)
        expected_writes.push_back(execute_instr(cmd_t'(cmd), dest_reg, src_a, src_b));
    end
    fail_count <= errors;
    checked <= results_seen;
    pending <= expected_writes.size();
  end

endmodule

FILE: sim/tb_cpu16_register_alu_execute.sv
// Testbench top for cpu16_register_alu_execute: drives directed and random
// instruction requests with random idling on both channels and gives the verdict.
// Depends on c16rae_pkg, the block's RTL and cpu16_execute_checker.
`timescale 1ns / 100ps

module tb_cpu16_register_alu_execute;
  import c16rae_pkg::*;

  localparam int ClkPeriod   = 20;
  localparam int RandomCount = 1400;
  localparam int CycleLimit  = 500000;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        out_ready = 1'b0;
  logic [3:0]  cmd = '0;
  logic [3:0]  dest_reg = '0;
  logic [3:0]  src_a = '0;
  logic [3:0]  src_b = '0;
  logic        in_ready;
  logic        out_valid;
  logic        write_valid;
  logic [3:0]  write_index;
  logic [15:0] write_value;
  logic        aux_valid;
  logic [15:0] aux_value;

  int fail_count;
  int checked;
  int pending;
  int sent = 0;
  int directed_sent = 0;
  int cycles = 0;
  int send_burst = 0;
  int take_burst = 0;

  cpu16_register_alu_execute dut (
    .clk, .rst, .in_valid, .in_ready, .cmd, .dest_reg, .src_a, .src_b,
    .out_valid, .out_ready, .write_valid, .write_index, .write_value,
    .aux_valid, .aux_value
  );

  cpu16_execute_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .cmd, .dest_reg, .src_a, .src_b,
    .out_valid, .out_ready, .write_valid, .write_index, .write_value,
    .aux_valid, .aux_value, .fail_count, .checked, .pending
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_request(cmd_t c, idx_t d, idx_t a, idx_t b);
    int gap;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 39) == 0) send_burst = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    dest_reg <= d;
    src_a <= a;
    src_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  initial begin
    int stall;
    forever begin
      if (take_burst > 0) begin
        stall = 0;
        take_burst--;
      end else begin
        stall = $urandom_range(0, 16);
        if ($urandom_range(0, 39) == 0) take_burst = $urandom_range(8, 40);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    cmd_t c;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // build the word extremes, then hit every opcode and corner
    send_request(CMD_CONST, 4'd1, 4'h8, 4'h0);
    send_request(CMD_CONST, 4'd2, 4'h1, 4'hF);
    send_request(CMD_SHIFT, 4'd1, 4'd1, 4'd2);
    send_request(CMD_CONST, 4'd3, 4'h1, 4'h9);
    send_request(CMD_SHIFT, 4'd1, 4'd1, 4'd3);
    send_request(CMD_CONST, 4'd4, 4'h0, 4'h1);
    send_request(CMD_SUB,   4'd5, 4'd0, 4'd4);
    send_request(CMD_SUB,   4'd6, 4'd1, 4'd4);
    send_request(CMD_CONST, 4'd15, 4'hF, 4'hF);
    send_request(CMD_ADD,   4'd7, 4'd6, 4'd4);
    send_request(CMD_MUL,   4'd8, 4'd5, 4'd5);
    send_request(CMD_UGT,   4'd9, 4'd1, 4'd6);
    send_request(CMD_SGT,   4'd10, 4'd1, 4'd6);
    send_request(CMD_ULT,   4'd11, 4'd1, 4'd6);
    send_request(CMD_SLT,   4'd12, 4'd1, 4'd6);
    send_request(CMD_EQ,    4'd13, 4'd1, 4'd7);
    send_request(CMD_SHIFT, 4'd14, 4'd1, 4'd0);
    send_request(CMD_CONST, 4'd2, 4'h0, 4'h7);
    send_request(CMD_SHIFT, 4'd9, 4'd1, 4'd2);
    send_request(CMD_CONST, 4'd3, 4'h1, 4'h3);
    send_request(CMD_SHIFT, 4'd10, 4'd6, 4'd3);
    send_request(CMD_CONST, 4'd2, 4'h0, 4'hF);
    send_request(CMD_SHIFT, 4'd9, 4'd5, 4'd2);
    send_request(CMD_SHIFT, 4'd11, 4'd6, 4'd5);
    send_request(CMD_AND,   4'd0, 4'd5, 4'd6);
    send_request(CMD_OR,    4'd12, 4'd1, 4'd4);
    send_request(CMD_XOR,   4'd13, 4'd5, 4'd6);
    send_request(CMD_COPY,  4'd2, 4'd0, 4'd15);
    send_request(CMD_STORE, 4'd15, 4'd15, 4'd15);
    send_request(CMD_MAJ,   4'd15, 4'd1, 4'd15);
    send_request(CMD_MAJ,   4'd3, 4'd5, 4'd3);
    directed_sent = sent;

    for (int i = 0; i < RandomCount; i++) begin
      if ($urandom_range(0, 3) == 0) c = CMD_CONST;
      else c = cmd_t'($urandom_range(0, 15));
      send_request(c, idx_t'($urandom_range(0, 15)), idx_t'($urandom_range(0, 15)),
                   idx_t'($urandom_range(0, 15)));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d instruction requests (%0d directed, rest random) over %0d cycles,",
             sent, directed_sent, cycles);
    $display("checked %0d results with random stalls on both channels, %0d mismatches.",
             checked, fail_count);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
